// ===== rtl/sef_pkg.sv =====
package sef_pkg;

  localparam int unsigned PIX_W           = 8;
  localparam int unsigned IMG_DIM_DEFAULT = 128;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Neighborhood of one interior pixel, compass names, top row is the oldest line.
  // The center pixel does not enter either Sobel sum and is not carried.
  typedef struct packed {
    logic [PIX_W-1:0] nw;
    logic [PIX_W-1:0] n;
    logic [PIX_W-1:0] ne;
    logic [PIX_W-1:0] w;
    logic [PIX_W-1:0] e;
    logic [PIX_W-1:0] sw;
    logic [PIX_W-1:0] s;
    logic [PIX_W-1:0] se;
    logic             last;
  } win_t;

endpackage

// ===== rtl/sef_front.sv =====
module sef_front #(
  parameter int unsigned IMG_DIM     = 128,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       pixel_i,
  input  logic                             frame_start_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count_i,
  output logic                             push_o,
  output sef_pkg::win_t                    push_data_o
);
  import sef_pkg::*;

  localparam int unsigned POS_W = $clog2(IMG_DIM);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [POS_W-1:0] row_q, col_q, row_d, col_d;
  logic [POS_W-1:0] cur_row, cur_col;
  logic             accept;

  logic             a_valid_q;
  logic [PIX_W-1:0] a_px_q;
  logic [POS_W-1:0] a_col_q;
  logic             a_prod_q, a_last_q;

  // Each entry holds {upper line, middle line} for one column.
  logic [2*PIX_W-1:0] mem [IMG_DIM];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] wr_data;

  // Two older window columns: index 0 top, 1 middle, 2 bottom.
  logic [PIX_W-1:0] c0_q [3];
  logic [PIX_W-1:0] c1_q [3];

  logic [CNT_W:0] level;

  assign level      = {1'b0, q_count_i} + {{CNT_W{1'b0}}, a_valid_q};
  assign in_stall_o = level >= (CNT_W+1)'(QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  assign cur_row = frame_start_i ? '0 : row_q;
  assign cur_col = frame_start_i ? '0 : col_q;

  always_comb begin
    col_d = cur_col;
    row_d = cur_row;
    if (cur_col == POS_W'(IMG_DIM - 1)) begin
      col_d = '0;
      if (cur_row == POS_W'(IMG_DIM - 1)) begin
        row_d = '0;
      end else begin
        row_d = cur_row + POS_W'(1);
      end
    end else begin
      col_d = cur_col + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_px_q   <= pixel_i;
      a_col_q  <= cur_col;
      a_prod_q <= (cur_row >= POS_W'(2)) && (cur_col >= POS_W'(2));
      a_last_q <= (cur_row == POS_W'(IMG_DIM - 1)) && (cur_col == POS_W'(IMG_DIM - 1));
    end
  end

  // Middle line moves up, the new pixel becomes the middle line.
  assign wr_data = {rd_q[PIX_W-1:0], a_px_q};

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      mem[a_col_q] <= wr_data;
    end
    if (accept) begin
      if (a_valid_q && (a_col_q == cur_col)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= mem[cur_col];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        c0_q[i] <= '0;
        c1_q[i] <= '0;
      end
    end else if (a_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        c0_q[i] <= c1_q[i];
      end
      c1_q[0] <= rd_q[2*PIX_W-1:PIX_W];
      c1_q[1] <= rd_q[PIX_W-1:0];
      c1_q[2] <= a_px_q;
    end
  end

  assign push_o           = a_valid_q && a_prod_q;
  assign push_data_o.nw   = c0_q[0];
  assign push_data_o.n    = c1_q[0];
  assign push_data_o.ne   = rd_q[2*PIX_W-1:PIX_W];
  assign push_data_o.w    = c0_q[1];
  assign push_data_o.e    = rd_q[PIX_W-1:0];
  assign push_data_o.sw   = c0_q[2];
  assign push_data_o.s    = c1_q[2];
  assign push_data_o.se   = a_px_q;
  assign push_data_o.last = a_last_q;

  a_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (q_count_i < CNT_W'(QUEUE_DEPTH)))
    else $error("front pushes into a full queue");

endmodule

// ===== rtl/sef_queue.sv =====
module sef_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  sef_pkg::win_t              push_data_i,
  input  logic                       pop_i,
  output sef_pkg::win_t              head_o,
  output logic                       nonempty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  import sef_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  win_t             slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  assign head_o     = slots_q[rd_ptr_q];
  assign nonempty_o = count_q != '0;
  assign count_o    = count_q;

  q_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_W'(DEPTH)) |-> (!push_i || pop_i))
    else $error("queue overflow");

  q_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> nonempty_o)
    else $error("queue underflow");

  q_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with empty count");

endmodule

// ===== rtl/sef_back.sv =====
module sef_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sef_pkg::win_t head_i,
  input  logic          nonempty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    edge_value_o,
  output logic          last_of_frame_o
);
  import sef_pkg::*;

  logic [PIX_W+1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [PIX_W+2:0] gx, gy;
  logic [PIX_W-1:0] cx, cy, sum;
  logic             out_valid_q;
  logic [PIX_W-1:0] edge_q;
  logic             last_q;

  // Sums above 255 saturate; everything else keeps its low byte, negatives wrap.
  function automatic logic [PIX_W-1:0] cap_byte(input logic signed [PIX_W+2:0] g);
    return (g > $signed((PIX_W+3)'(255))) ? {PIX_W{1'b1}} : g[PIX_W-1:0];
  endfunction

  always_comb begin
    gx_pos = {2'b00, head_i.ne} + {1'b0, head_i.e, 1'b0} + {2'b00, head_i.se};
    gx_neg = {2'b00, head_i.nw} + {1'b0, head_i.w, 1'b0} + {2'b00, head_i.sw};
    gy_pos = {2'b00, head_i.nw} + {1'b0, head_i.n, 1'b0} + {2'b00, head_i.ne};
    gy_neg = {2'b00, head_i.sw} + {1'b0, head_i.s, 1'b0} + {2'b00, head_i.se};
    gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    cx     = cap_byte(gx);
    cy     = cap_byte(gy);
    sum    = cx + cy;
  end

  assign pop_o = nonempty_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= nonempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      edge_q <= {PIX_W{1'b1}} - sum;
      last_q <= head_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign edge_value_o    = edge_q;
  assign last_of_frame_o = last_q;

endmodule

// ===== rtl/sobel_edge_filter_3x3.sv =====
// Sobel edge filter over square grey images of IMG_DIM x IMG_DIM pixels, streamed in
// raster order with frame_start on the first pixel of each image. One pixel is
// transferred per clock cycle when the output side keeps up; the rate is set by the
// line store in the front, which is read through one port and rewritten through a
// second port once per pixel.
// Each interior pixel (not in the first or last row or column) yields one result,
// issued when the pixel below and to the right of it arrives; border positions yield
// nothing. A result passes a front register and the queue into the output register.
// last_of_frame marks the result of the last interior pixel of the image. An image that
// runs past its end without frame_start simply wraps to a new image.
module sobel_edge_filter_3x3 #(
  parameter int unsigned IMG_DIM     = sef_pkg::IMG_DIM_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = sef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] pixel_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] edge_value_o,
  output logic       last_of_frame_o
);
  import sef_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // The front tracks the pixel position, keeps two lines in one line store and the
  // window, and pushes a finished neighborhood for every interior pixel. It stalls
  // its input only when the queue could not take what is already in flight.
  logic             push;
  win_t             push_data;
  win_t             head;
  logic             nonempty;
  logic             pop;
  logic [CNT_W-1:0] q_count;

  sef_front #(
    .IMG_DIM    (IMG_DIM),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // The queue decouples the two halves, so a stalled output does not stop the
  // front until the queue has filled.
  sef_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (nonempty),
    .count_o    (q_count)
  );

  // The back computes both gradients, caps each at 255, adds them, subtracts the sum
  // from 255 and holds the result in the output register until the transfer completes.
  sef_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .nonempty_i     (nonempty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .edge_value_o   (edge_value_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

// ===== verif/sobel_edge_filter_3x3_tb.sv =====
module sobel_edge_filter_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The image size and pixel width come from the package defaults, which are also
  // the defaults of the block under test.
  localparam int unsigned IMG   = sef_pkg::IMG_DIM_DEFAULT;
  localparam int unsigned POS_W = $clog2(IMG);

  // A directed case whose expected edge value is left to the predictor.
  localparam int PREDICTED = -1;

  // The watchdog gives up after this many cycles in which no transfer happens on
  // either side. A correct block never gets anywhere near this limit, even with the
  // random idling on both sides.
  localparam int unsigned STALL_LIMIT = 2000;

  // The block passes each result through a front register and the queue into its output
  // register, so a short grace period at the end catches any stray results.
  localparam int unsigned TAIL_CYCLES = 20;

  typedef logic [sef_pkg::PIX_W-1:0] pix_t;

  typedef struct {
    pix_t value;
    logic last;
  } edge_res_t;

  // Image patterns used to build stimulus. The noise pattern draws each pixel from
  // a base value plus a random offset of up to the second parameter.
  typedef enum logic [2:0] {
    PAT_FLAT,
    PAT_VEDGE,
    PAT_HEDGE,
    PAT_CHECKER,
    PAT_NOISE
  } pattern_e;

  // One image of stimulus: a pattern with two levels and a split position, the number
  // of full rows, and a tail of pixels in the next row. A nonzero tail leaves the image
  // unfinished, so the next image starts in the middle of this one.
  typedef struct {
    pattern_e    pat;
    pix_t        a;
    pix_t        b;
    int unsigned split;
    int unsigned rows;
    int unsigned tail;
    int          exp_value;
  } shot_t;

  logic clk_i;
  logic rst_ni        = 1'b0;
  logic in_valid_i    = 1'b0;
  logic in_stall_o;
  pix_t pixel_i       = '0;
  logic frame_start_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i   = 1'b0;
  pix_t edge_value_o;
  logic last_of_frame_o;

  sobel_edge_filter_3x3 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .edge_value_o   (edge_value_o),
    .last_of_frame_o(last_of_frame_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Edge values still owed by the block, oldest first.
  edge_res_t   edge_q[$];
  int unsigned mismatches = 0;
  int unsigned sent_count = 0;
  int unsigned quiet_cycles = 0;

  // When set, neither side idles. Every sixth random frame turns this on to give
  // long stretches at full rate.
  bit calm = 1'b0;

  // Shadow copy of the filter state: the two line stores, the 3x3 window and the
  // position of the next pixel. Line store entries that were never written start at
  // zero here; the block never lets such an entry reach a result.
  pix_t             line_above [IMG] = '{default: '0};
  pix_t             line_prev  [IMG] = '{default: '0};
  pix_t             nbhd       [9]   = '{default: '0};
  logic [POS_W-1:0] cur_row = '0;
  logic [POS_W-1:0] cur_col = '0;

  // The directed cases. Flat images have a zero gradient everywhere, so every interior
  // result is 255 and is typed in. The edges between 0 and 255 drive the gradients to
  // their largest positive and negative values, which exercises the cap at 255 and the
  // wrap of negative sums; checkerboard gradients cancel to zero. These go through the
  // predictor. Some images end part way through a row, so the following frame start
  // lands in the middle of an image, and one image is too short to produce any result.
  shot_t directed_shots [13] = '{
    '{PAT_FLAT,    8'd0,   8'd0,   0,  3, 0,  255},
    '{PAT_FLAT,    8'd255, 8'd255, 0,  3, 5,  255},
    '{PAT_VEDGE,   8'd0,   8'd255, 64, 3, 0,  PREDICTED},
    '{PAT_VEDGE,   8'd255, 8'd0,   64, 3, 0,  PREDICTED},
    '{PAT_HEDGE,   8'd0,   8'd255, 2,  4, 0,  PREDICTED},
    '{PAT_HEDGE,   8'd255, 8'd0,   2,  4, 0,  PREDICTED},
    '{PAT_CHECKER, 8'd0,   8'd255, 0,  3, 0,  PREDICTED},
    '{PAT_CHECKER, 8'd255, 8'd0,   0,  3, 70, PREDICTED},
    '{PAT_VEDGE,   8'd17,  8'd200, 1,  3, 0,  PREDICTED},
    '{PAT_HEDGE,   8'd100, 8'd37,  1,  3, 9,  PREDICTED},
    '{PAT_NOISE,   8'd0,   8'd255, 0,  3, 1,  PREDICTED},
    '{PAT_FLAT,    8'd128, 8'd128, 0,  2, 3,  255},
    '{PAT_FLAT,    8'd1,   8'd1,   0,  2, 0,  PREDICTED}
  };

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  function automatic pix_t clip_byte(input int s);
    if (s > 255) begin
      return '1;
    end
    return pix_t'(s);
  endfunction

  // Advances the shadow state by one pixel and reports whether this pixel completes
  // the window of an interior pixel, and if so, the edge value of that pixel.
  function automatic bit sobel_predict(input pix_t px, input logic fs,
                                       output edge_res_t res);
    pix_t up;
    pix_t mid;
    pix_t grad_sum;
    int   gx;
    int   gy;
    bit   hit;
    if (fs) begin
      cur_row = '0;
      cur_col = '0;
    end
    up  = line_above[cur_col];
    mid = line_prev[cur_col];
    line_above[cur_col] = mid;
    line_prev[cur_col]  = px;
    for (int r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = up;
    nbhd[5] = mid;
    nbhd[8] = px;

    hit = (cur_row >= 2) && (cur_col >= 2);
    gx = (int'(nbhd[2]) + 2 * int'(nbhd[5]) + int'(nbhd[8]))
       - (int'(nbhd[0]) + 2 * int'(nbhd[3]) + int'(nbhd[6]));
    gy = (int'(nbhd[0]) + 2 * int'(nbhd[1]) + int'(nbhd[2]))
       - (int'(nbhd[6]) + 2 * int'(nbhd[7]) + int'(nbhd[8]));
    grad_sum  = clip_byte(gx) + clip_byte(gy);
    res.value = 8'hFF - grad_sum;
    res.last  = (cur_row == IMG - 1) && (cur_col == IMG - 1);

    // The position wraps after the last pixel, so an image that runs on without a
    // frame start simply begins again at the top left.
    if (cur_col == IMG - 1) begin
      cur_col = '0;
      cur_row = (cur_row == IMG - 1) ? '0 : cur_row + 1'b1;
    end else begin
      cur_col = cur_col + 1'b1;
    end
    return hit;
  endfunction

  function automatic pix_t pattern_pixel(input shot_t s, input int unsigned row,
                                         input int unsigned col);
    case (s.pat)
      PAT_FLAT:    return s.a;
      PAT_VEDGE:   return (col < s.split) ? s.a : s.b;
      PAT_HEDGE:   return (row < s.split) ? s.a : s.b;
      PAT_CHECKER: return (((row ^ col) & 1) != 0) ? s.a : s.b;
      default:     return pix_t'(s.a + $urandom_range(0, s.b));
    endcase
  endfunction

  // Offers one pixel, possibly after a few idle cycles, and holds it until the
  // transfer completes. Handshake signals are sampled right at the rising edge, so
  // they hold the values that the block itself saw at that edge. Nothing is assigned
  // after the transfer, which leaves the next call free to either keep valid high or
  // drop it in the same time step.
  task automatic send_pixel(input pix_t px, input logic fs, input int typed);
    edge_res_t res;
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= px;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    if (sobel_predict(px, fs, res)) begin
      if (typed != PREDICTED) begin
        res.value = pix_t'(typed);
      end
      edge_q.push_back(res);
    end
    sent_count++;
  endtask

  // Streams one image. With noisy set, a stray frame start may appear anywhere inside
  // the image and restart the position while the line stores keep their contents.
  task automatic play_shot(input shot_t s, input bit noisy);
    int unsigned n;
    logic        fs;
    n = s.rows * IMG + s.tail;
    for (int unsigned i = 0; i < n; i++) begin
      fs = (i == 0) || (noisy && $urandom_range(0, 299) == 0);
      send_pixel(pattern_pixel(s, (i / IMG) % IMG, i % IMG), fs, s.exp_value);
    end
  endtask

  // Holds the input side off until every outstanding result has been transferred.
  // It always waits on the clock before it returns, so the next pixel is driven in a
  // later time step than the idle value.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (edge_q.size() != 0);
  endtask

  // Output side: checks each transfer against the oldest expectation and then decides
  // at random, unless calm is set, whether to stall the next cycle.
  always @(posedge clk_i) begin : result_check
    edge_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (edge_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, edge value %0d", edge_value_o));
      end else begin
        want = edge_q.pop_front();
        if (edge_value_o !== want.value) begin
          report_mismatch($sformatf("edge value %0d, expected %0d",
                                    edge_value_o, want.value));
        end
        if (last_of_frame_o !== want.last) begin
          report_mismatch($sformatf("last of frame %b, expected %b",
                                    last_of_frame_o, want.last));
        end
      end
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 28);
  end

  // Ends the run when neither side has seen a transfer for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    shot_t       s;
    int unsigned frames;
    int unsigned rand_start;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_shots[k]) begin
      play_shot(directed_shots[k], 1'b0);
    end
    drain_results();

    // One full image that runs a few rows past its end without a new frame start.
    // This is the only place where the last interior result of an image shows up,
    // and it checks that the position wraps to a fresh image on its own.
    s = '{PAT_NOISE, 8'd40, 8'd90, 0, IMG + 3, 17, PREDICTED};
    play_shot(s, 1'b0);

    // Random images. Most are tall enough to produce results; every fifth one is a
    // broken image of fewer than two full rows. Now and then the sender waits for
    // the output side to catch up completely.
    frames     = 0;
    rand_start = sent_count;
    while (sent_count - rand_start < 1750) begin
      s.pat       = pattern_e'($urandom_range(0, 4));
      s.a         = pix_t'($urandom_range(0, 255));
      s.b         = pix_t'($urandom_range(0, 255));
      s.split     = (s.pat == PAT_HEDGE) ? $urandom_range(0, 4) : $urandom_range(0, IMG - 1);
      s.rows      = (frames % 5 == 4) ? $urandom_range(0, 1) : $urandom_range(2, 5);
      s.tail      = $urandom_range(0, IMG - 1);
      s.exp_value = PREDICTED;
      calm = (frames % 6 == 3);
      play_shot(s, 1'b1);
      calm = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        drain_results();
      end
      frames++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && edge_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sef_pkg.sv
rtl/sef_front.sv
rtl/sef_queue.sv
rtl/sef_back.sv
rtl/sobel_edge_filter_3x3.sv
verif/sobel_edge_filter_3x3_tb.sv
